// ===== hw/rtl/sde_pkg.sv =====
// Shared widths, coefficient tables and fixed-point helpers for the seawater density unit.
`default_nettype none

package sde_pkg;

  // Field widths.
  localparam int SAL_W  = 22;
  localparam int TEMP_W = 23;
  localparam int PRES_W = 23;
  localparam int DENS_W = 27;

  // Internal value format: signed Q44 in 64 bits.
  localparam int VAL_W = 64;
  localparam int FRAC  = 44;

  // Scaling of the inputs and of the later steps.
  localparam int SAL_FRAC  = 16;
  localparam int TEMP_FRAC = 16;
  localparam int PRES_FRAC = 12;
  localparam int SQRT_PAD  = 40;
  localparam int Q_FRAC    = 32;
  localparam int NUM_SHIFT = 36;
  localparam int DEN_SHIFT = 28;
  localparam int OUT_SHIFT = 28;

  // Square root unit.
  localparam int RAD_W     = SAL_W + SQRT_PAD;
  localparam int SQ_W      = 64;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SQ_NITER  = RAD_W / 2 + 1;
  localparam int SQ_PER    = 4;
  localparam int SQ_STG    = (SQ_NITER + SQ_PER - 1) / SQ_PER;
  localparam int S15_W     = ROOT_W + SAL_W;

  // Quotient unit.
  localparam int DIV_NW  = PRES_W + NUM_SHIFT;
  localparam int DIV_DW  = 63 - DEN_SHIFT;
  localparam int DIV_PER = 4;
  localparam int DIV_STG = (DIV_NW + DIV_PER - 1) / DIV_PER;

  // Polynomials in temperature, each padded to six coefficients (lowest power first).
  localparam int NPOLY = 10;
  localparam int NCOEF = 6;
  localparam int P_RW  = 0;
  localparam int P_RS  = 1;
  localparam int P_RQ  = 2;
  localparam int P_KW  = 3;
  localparam int P_KS  = 4;
  localparam int P_KQ  = 5;
  localparam int P_KA  = 6;
  localparam int P_KAS = 7;
  localparam int P_KB  = 8;
  localparam int P_KBS = 9;

  // Each coefficient is CM / 10^CE.
  localparam int CM [NPOLY][NCOEF] = '{
    '{999842594, 6793952, -909529, 1001685, -1120083, 6536332},
    '{824493, -40899, 76438, -82467, 53875, 0},
    '{-572466, 10227, -16546, 0, 0, 0},
    '{1965221, 1484206, -2327105, 1360477, -5155288, 0},
    '{546746, -603459, 109987, -61670, 0, 0},
    '{7944, 16483, -53009, 0, 0, 0},
    '{3239908, 143713, 116092, -577905, 0, 0},
    '{22838, -10981, -16078, 0, 0, 0},
    '{850935, -612293, 52787, 0, 0, 0},
    '{-99348, 20816, 91697, 0, 0, 0}
  };
  localparam int CE [NPOLY][NCOEF] = '{
    '{6, 8, 8, 10, 12, 15},
    '{6, 7, 9, 11, 13, 0},
    '{8, 8, 10, 0, 0, 0},
    '{2, 4, 6, 8, 11, 0},
    '{4, 6, 7, 9, 0, 0},
    '{5, 6, 8, 0, 0, 0},
    '{6, 8, 9, 12, 0, 0},
    '{7, 9, 10, 0, 0, 0},
    '{10, 11, 12, 0, 0, 0},
    '{11, 12, 14, 0, 0, 0}
  };

  // m / 10^e in Q44, rounded to nearest with halves away from zero.
  // Bitwise long division, evaluated at elaboration only.
  function automatic logic signed [63:0] fixq(input int m, input int e);
    logic [127:0] d;
    logic [127:0] n;
    logic [127:0] r;
    logic [127:0] q;
    logic [63:0]  q64;
    int           am;
    d = 128'd1;
    for (int i = 0; i < e; i++) d = d * 128'd10;
    am = (m < 0) ? -m : m;
    n = 128'(am) << FRAC;
    r = '0;
    q = '0;
    for (int i = 127; i >= 0; i--) begin
      r = {r[126:0], n[i]};
      q = {q[126:0], 1'b0};
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    if ({r[126:0], 1'b0} >= d) q = q + 128'd1;
    q64 = q[63:0];
    return (m < 0) ? -q64 : q64;
  endfunction

  function automatic logic signed [63:0] qcoef(input int k, input int j);
    return fixq(CM[k][j], CE[k][j]);
  endfunction

  // Lone coefficients of the s^2 density term and the s^1.5 pressure term.
  localparam logic signed [63:0] RSS_Q = fixq(48314, 8);
  localparam logic signed [63:0] KQP_Q = fixq(191075, 9);

  // Output limits.
  localparam logic signed [63:0] DENS_LO  = 64'sd980 <<< FRAC;
  localparam logic signed [63:0] DENS_HI  = 64'sd1088 <<< FRAC;
  localparam logic [DENS_W-1:0]  DENS_TOP = DENS_W'(DENS_HI >>> OUT_SHIFT);

endpackage

`default_nettype wire

// ===== hw/rtl/seawater_density_eos80_unit.sv =====
// Top level of the EOS-80 seawater density pipeline.
//
// Takes salinity (promille, Q.16), temperature (deg C, signed Q.16) and gauge
// pressure (bar, Q.12) and returns density in kg/m^3 as Q.16, saturated to
// 980..1088; a collapsed bulk modulus gives 1088. One beat enters per clock
// unless the output stalls. The pipeline has one shared advance: when the
// output register holds a beat that is not taken, every stage holds and
// in_ready_o drops, so nothing is lost or repeated. The pipeline is a chain
// of units: ten stages of Horner steps in temperature, the modulus and
// pressure products, and a fifteen-stage restoring divider that forms
// p/(K-p) four quotient bits per stage.
`default_nettype none

module seawater_density_eos80_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sde_pkg::SAL_W-1:0]          salinity_i,
  input  logic signed [sde_pkg::TEMP_W-1:0]  temperature_i,
  input  logic [sde_pkg::PRES_W-1:0]         pressure_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sde_pkg::DENS_W-1:0]         density_o
);

  import sde_pkg::*;

  localparam int LAT    = 35;
  localparam int S_DLY  = 10;
  localparam int P_DLY  = 17;
  localparam int X4_DLY = 6;
  localparam int RH_DLY = 19;
  localparam int Z_DLY  = 17;
  localparam int EW     = 96;

  logic en;
  logic [LAT:0] vld_q;

  logic [SAL_W-1:0]         sal_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic [PRES_W-1:0]        pres_q;
  logic [SAL_W-1:0]         sal_dly_q [1:S_DLY];
  logic [PRES_W-1:0]        pres_dly_q [1:P_DLY];

  logic signed [VAL_W-1:0]  poly [NPOLY];
  logic signed [VAL_W-1:0]  c3;
  logic signed [VAL_W-1:0]  x4;
  logic signed [VAL_W-1:0]  x4_dly_q [X4_DLY];
  logic [ROOT_W-1:0]        root;
  logic [S15_W-1:0]         s15_9_q;
  logic [S15_W-1:0]         s15_10_q;

  logic signed [SAL_W:0]    sal0_b;
  logic signed [SAL_W:0]    sal2_b;
  logic signed [SAL_W:0]    sal10_b;
  logic signed [S15_W:0]    s15_b;
  logic signed [PRES_W:0]   p12_b;
  logic signed [PRES_W:0]   p13_b;
  logic signed [PRES_W:0]   p14_b;
  logic signed [VAL_W-1:0]  p14_neg;

  logic signed [VAL_W-1:0]  r1, r2, a1, a2, bc, w1, w2;
  logic signed [VAL_W-1:0]  rho0_q, acoef_q, bulkw_q;
  logic signed [VAL_W-1:0]  bp, bpp, ap;
  logic signed [VAL_W-1:0]  ap16_q;
  logic signed [VAL_W-1:0]  den_q;
  logic [DIV_DW-1:0]        den16;
  logic                     den_zero;
  logic [DIV_NW-1:0]        quot;
  logic signed [VAL_W-1:0]  rho_dly_q [RH_DLY];
  logic                     zero_dly_q [Z_DLY];
  logic signed [EW-1:0]     dens_e;
  logic [VAL_W-1:0]         dens_cl;
  logic [VAL_W-1:0]         dens_rnd;
  logic [DENS_W-1:0]        dens_d;
  logic [DENS_W-1:0]        dens_q;

  // The whole pipeline advances together unless the output beat is held.
  assign en          = out_ready_i | ~vld_q[LAT];
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT];
  assign density_o   = dens_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-1:0], in_valid_i};
    end
  end

  // Input registers and the delay lines for salinity and pressure.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sal_q  <= salinity_i;
      temp_q <= temperature_i;
      pres_q <= pressure_i;
      sal_dly_q[1]  <= sal_q;
      pres_dly_q[1] <= pres_q;
      for (int i = 2; i <= S_DLY; i++) sal_dly_q[i] <= sal_dly_q[i-1];
      for (int i = 2; i <= P_DLY; i++) pres_dly_q[i] <= pres_dly_q[i-1];
    end
  end

  assign sal0_b  = signed'({1'b0, sal_q});
  assign sal2_b  = signed'({1'b0, sal_dly_q[2]});
  assign sal10_b = signed'({1'b0, sal_dly_q[S_DLY]});
  assign s15_b   = signed'({1'b0, s15_10_q});
  assign p12_b   = signed'({1'b0, pres_dly_q[12]});
  assign p13_b   = signed'({1'b0, pres_dly_q[13]});
  assign p14_b   = signed'({1'b0, pres_dly_q[14]});
  assign p14_neg = -signed'({9'b0, pres_dly_q[14], 32'b0});

  // Temperature polynomials.
  sde_poly u_poly (
    .clk_i(clk_i),
    .en_i (en),
    .t_i  (temp_q),
    .p_o  (poly)
  );

  // The s^2 density term: coefficient times s, then times s again.
  sde_mulsh #(.AW(VAL_W), .BW(SAL_W+1), .SH(SAL_FRAC), .OW(VAL_W)) u_rss1 (
    .clk_i(clk_i), .en_i(en), .a_i(RSS_Q), .b_i(sal0_b), .c_i('0), .r_o(c3)
  );
  sde_mulsh #(.AW(VAL_W), .BW(SAL_W+1), .SH(SAL_FRAC), .OW(VAL_W)) u_rss2 (
    .clk_i(clk_i), .en_i(en), .a_i(c3), .b_i(sal2_b), .c_i('0), .r_o(x4)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      x4_dly_q[0] <= x4;
      for (int i = 1; i < X4_DLY; i++) x4_dly_q[i] <= x4_dly_q[i-1];
    end
  end

  // s^1.5 as sqrt(s) times s, in Q44.
  sde_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .s_i   (sal_q),
    .root_o(root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      s15_9_q  <= S15_W'(root) * S15_W'(sal_dly_q[8]);
      s15_10_q <= s15_9_q;
    end
  end

  // Salinity terms of the density, modulus and pressure coefficients.
  sde_mulsh #(.AW(VAL_W), .BW(SAL_W+1), .SH(SAL_FRAC), .OW(VAL_W)) u_r1 (
    .clk_i(clk_i), .en_i(en), .a_i(poly[P_RS]), .b_i(sal10_b), .c_i(poly[P_RW]), .r_o(r1)
  );
  sde_mulsh #(.AW(VAL_W), .BW(S15_W+1), .SH(FRAC), .OW(VAL_W)) u_r2 (
    .clk_i(clk_i), .en_i(en), .a_i(poly[P_RQ]), .b_i(s15_b), .c_i(x4_dly_q[X4_DLY-1]),
    .r_o(r2)
  );
  sde_mulsh #(.AW(VAL_W), .BW(SAL_W+1), .SH(SAL_FRAC), .OW(VAL_W)) u_a1 (
    .clk_i(clk_i), .en_i(en), .a_i(poly[P_KAS]), .b_i(sal10_b), .c_i(poly[P_KA]), .r_o(a1)
  );
  sde_mulsh #(.AW(VAL_W), .BW(S15_W+1), .SH(FRAC), .OW(VAL_W)) u_a2 (
    .clk_i(clk_i), .en_i(en), .a_i(KQP_Q), .b_i(s15_b), .c_i('0), .r_o(a2)
  );
  sde_mulsh #(.AW(VAL_W), .BW(SAL_W+1), .SH(SAL_FRAC), .OW(VAL_W)) u_bc (
    .clk_i(clk_i), .en_i(en), .a_i(poly[P_KBS]), .b_i(sal10_b), .c_i(poly[P_KB]), .r_o(bc)
  );
  sde_mulsh #(.AW(VAL_W), .BW(SAL_W+1), .SH(SAL_FRAC), .OW(VAL_W)) u_w1 (
    .clk_i(clk_i), .en_i(en), .a_i(poly[P_KS]), .b_i(sal10_b), .c_i(poly[P_KW]), .r_o(w1)
  );
  sde_mulsh #(.AW(VAL_W), .BW(S15_W+1), .SH(FRAC), .OW(VAL_W)) u_w2 (
    .clk_i(clk_i), .en_i(en), .a_i(poly[P_KQ]), .b_i(s15_b), .c_i('0), .r_o(w2)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      rho0_q  <= r1 + r2;
      acoef_q <= a1 + a2;
      bulkw_q <= w1 + w2;
    end
  end

  // Pressure terms of the bulk modulus; the B*p^2 product also takes off p.
  sde_mulsh #(.AW(VAL_W), .BW(PRES_W+1), .SH(PRES_FRAC), .OW(VAL_W)) u_bp (
    .clk_i(clk_i), .en_i(en), .a_i(bc), .b_i(p12_b), .c_i('0), .r_o(bp)
  );
  sde_mulsh #(.AW(VAL_W), .BW(PRES_W+1), .SH(PRES_FRAC), .OW(VAL_W)) u_bpp (
    .clk_i(clk_i), .en_i(en), .a_i(bp), .b_i(p14_b), .c_i(p14_neg), .r_o(bpp)
  );
  sde_mulsh #(.AW(VAL_W), .BW(PRES_W+1), .SH(PRES_FRAC), .OW(VAL_W)) u_ap (
    .clk_i(clk_i), .en_i(en), .a_i(acoef_q), .b_i(p13_b), .c_i(bulkw_q), .r_o(ap)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ap16_q <= ap;
      den_q  <= bpp + ap16_q;
    end
  end

  // Denominator K - p in units of 2^-16 bar; zero means the modulus collapsed.
  assign den16    = (den_q > 0) ? den_q[62:DEN_SHIFT] : '0;
  assign den_zero = (den16 == '0);

  sde_div u_div (
    .clk_i(clk_i),
    .en_i (en),
    .n_i  ({pres_dly_q[P_DLY], {NUM_SHIFT{1'b0}}}),
    .d_i  (den16),
    .q_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      rho_dly_q[0]  <= rho0_q;
      zero_dly_q[0] <= den_zero;
      for (int i = 1; i < RH_DLY; i++) rho_dly_q[i] <= rho_dly_q[i-1];
      for (int i = 1; i < Z_DLY; i++) zero_dly_q[i] <= zero_dly_q[i-1];
    end
  end

  // rho = rho0 + rho0 * q, kept wide so the clamp below sees the true sum.
  sde_mulsh #(.AW(VAL_W), .BW(DIV_NW+1), .SH(Q_FRAC), .OW(EW)) u_rho (
    .clk_i(clk_i),
    .en_i (en),
    .a_i  (rho_dly_q[RH_DLY-1]),
    .b_i  (signed'({1'b0, quot})),
    .c_i  (EW'(rho_dly_q[RH_DLY-1])),
    .r_o  (dens_e)
  );

  // Clamp to the density range and round to Q.16.
  always_comb begin
    if (dens_e < EW'(DENS_LO)) begin
      dens_cl = DENS_LO;
    end else if (dens_e > EW'(DENS_HI)) begin
      dens_cl = DENS_HI;
    end else begin
      dens_cl = dens_e[VAL_W-1:0];
    end
    dens_rnd = dens_cl + (VAL_W'(1) << (OUT_SHIFT - 1));
    if (zero_dly_q[Z_DLY-1]) begin
      dens_d = DENS_TOP;
    end else begin
      dens_d = dens_rnd[OUT_SHIFT+DENS_W-1:OUT_SHIFT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dens_q <= dens_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sde_mulsh.sv =====
// Two-stage signed multiply, add and arithmetic right shift built from 33x33 partial products.
`default_nettype none

module sde_mulsh #(
  parameter int AW = 64,
  parameter int BW = 23,
  parameter int SH = 16,
  parameter int OW = 64
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  input  logic signed [OW-1:0] c_i,
  output logic signed [OW-1:0] r_o
);

  localparam int NA     = (AW + 31) / 32;
  localparam int NB     = (BW + 31) / 32;
  localparam int W_PROD = AW + BW;
  localparam int W_ADD  = OW + SH;
  localparam int PW     = ((W_PROD > W_ADD) ? W_PROD : W_ADD) + 1;

  logic signed [32:0] a_pc [NA];
  logic signed [32:0] b_pc [NB];
  logic signed [65:0] prod_q [NA][NB];
  logic signed [OW-1:0] c_q;
  logic signed [PW-1:0] sum;
  logic signed [OW-1:0] r_q;

  // Split the operands: low pieces are unsigned, the top piece carries the sign.
  for (genvar i = 0; i < NA; i++) begin : g_apc
    if (i == NA - 1) begin : g_top
      assign a_pc[i] = 33'(signed'(a_i[AW-1:32*i]));
    end else begin : g_low
      assign a_pc[i] = {1'b0, a_i[32*i+31:32*i]};
    end
  end
  for (genvar j = 0; j < NB; j++) begin : g_bpc
    if (j == NB - 1) begin : g_top
      assign b_pc[j] = 33'(signed'(b_i[BW-1:32*j]));
    end else begin : g_low
      assign b_pc[j] = {1'b0, b_i[32*j+31:32*j]};
    end
  end

  // First stage: partial products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          prod_q[i][j] <= a_pc[i] * b_pc[j];
        end
      end
      c_q <= c_i;
    end
  end

  // Second stage: the addend sits above the shift, so the floor applies to the product alone.
  always_comb begin
    sum = PW'(c_q) <<< SH;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (PW'(prod_q[i][j]) <<< (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= OW'(sum >>> SH);
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sde_poly.sv =====
// Ten Horner lanes in temperature, five multiply-add steps of two stages each.
`default_nettype none

module sde_poly (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [sde_pkg::TEMP_W-1:0]  t_i,
  output logic signed [sde_pkg::VAL_W-1:0]   p_o [sde_pkg::NPOLY]
);

  import sde_pkg::*;

  localparam int NSTEP = NCOEF - 1;
  localparam int TDLY  = 2 * (NSTEP - 1);

  logic signed [TEMP_W-1:0] t_q [TDLY];
  logic signed [VAL_W-1:0]  acc [NPOLY][NSTEP+1];

  // Temperature travels alongside the lanes, two stages per step.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0] <= t_i;
      for (int n = 1; n < TDLY; n++) begin
        t_q[n] <= t_q[n-1];
      end
    end
  end

  for (genvar k = 0; k < NPOLY; k++) begin : g_lane
    assign acc[k][0] = qcoef(k, NCOEF - 1);
    for (genvar j = 0; j < NSTEP; j++) begin : g_step
      logic signed [TEMP_W-1:0] t_tap;
      if (j == 0) begin : g_first
        assign t_tap = t_i;
      end else begin : g_later
        assign t_tap = t_q[2*j-1];
      end
      sde_mulsh #(
        .AW(VAL_W),
        .BW(TEMP_W),
        .SH(TEMP_FRAC),
        .OW(VAL_W)
      ) u_step (
        .clk_i(clk_i),
        .en_i (en_i),
        .a_i  (acc[k][j]),
        .b_i  (t_tap),
        .c_i  (qcoef(k, NCOEF - 2 - j)),
        .r_o  (acc[k][j+1])
      );
    end
    assign p_o[k] = acc[k][NSTEP];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sde_sqrt.sv =====
// Pipelined integer square root of salinity scaled by 2^40, four result bits per stage.
`default_nettype none

module sde_sqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [sde_pkg::SAL_W-1:0]     s_i,
  output logic [sde_pkg::ROOT_W-1:0]    root_o
);

  import sde_pkg::*;

  logic [RAD_W-1:0] x_in [SQ_STG];
  logic [SQ_W-1:0]  r_in [SQ_STG];
  logic [RAD_W-1:0] x_d  [SQ_STG];
  logic [SQ_W-1:0]  r_d  [SQ_STG];
  logic [RAD_W-1:0] x_q  [SQ_STG];
  logic [SQ_W-1:0]  r_q  [SQ_STG];

  assign x_in[0] = {s_i, {SQRT_PAD{1'b0}}};
  assign r_in[0] = '0;

  for (genvar g = 0; g < SQ_STG; g++) begin : g_stg
    if (g > 0) begin : g_chain
      assign x_in[g] = x_q[g-1];
      assign r_in[g] = r_q[g-1];
    end

    // Remainder-based digit recurrence, trial value divided by four each iteration.
    always_comb begin : p_iter
      logic [SQ_W-1:0] x;
      logic [SQ_W-1:0] r;
      logic [SQ_W-1:0] b;
      x = SQ_W'(x_in[g]);
      r = r_in[g];
      b = '0;
      for (int m = 0; m < SQ_PER; m++) begin
        if (g * SQ_PER + m < SQ_NITER) begin
          b = SQ_W'(1) << (2 * (SQ_NITER - 1 - (g * SQ_PER + m)));
          if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
        end
      end
      x_d[g] = RAD_W'(x);
      r_d[g] = r;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g] <= x_d[g];
        r_q[g] <= r_d[g];
      end
    end
  end

  assign root_o = r_q[SQ_STG-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/sde_div.sv =====
// Pipelined restoring divider for the quotient p/(K-p), four bits per stage.
`default_nettype none

module sde_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [sde_pkg::DIV_NW-1:0]    n_i,
  input  logic [sde_pkg::DIV_DW-1:0]    d_i,
  output logic [sde_pkg::DIV_NW-1:0]    q_o
);

  import sde_pkg::*;

  logic [DIV_NW-1:0] n_in [DIV_STG];
  logic [DIV_DW-1:0] d_in [DIV_STG];
  logic [DIV_DW-1:0] r_in [DIV_STG];
  logic [DIV_NW-1:0] q_in [DIV_STG];
  logic [DIV_DW-1:0] r_d  [DIV_STG];
  logic [DIV_NW-1:0] q_d  [DIV_STG];
  logic [DIV_NW-1:0] n_q  [DIV_STG];
  logic [DIV_DW-1:0] d_q  [DIV_STG];
  logic [DIV_DW-1:0] r_q  [DIV_STG];
  logic [DIV_NW-1:0] q_q  [DIV_STG];

  assign n_in[0] = n_i;
  assign d_in[0] = d_i;
  assign r_in[0] = '0;
  assign q_in[0] = '0;

  for (genvar g = 0; g < DIV_STG; g++) begin : g_stg
    if (g > 0) begin : g_chain
      assign n_in[g] = n_q[g-1];
      assign d_in[g] = d_q[g-1];
      assign r_in[g] = r_q[g-1];
      assign q_in[g] = q_q[g-1];
    end

    // Bring down one numerator bit, subtract the divisor when it fits.
    always_comb begin : p_iter
      logic [DIV_DW:0]   rr;
      logic [DIV_DW-1:0] r;
      logic [DIV_NW-1:0] q;
      rr = '0;
      r  = r_in[g];
      q  = q_in[g];
      for (int m = 0; m < DIV_PER; m++) begin
        if (g * DIV_PER + m < DIV_NW) begin
          rr = {r, n_in[g][DIV_NW-1-(g*DIV_PER+m)]};
          if (rr >= {1'b0, d_in[g]}) begin
            rr = rr - {1'b0, d_in[g]};
            q[DIV_NW-1-(g*DIV_PER+m)] = 1'b1;
          end
          r = rr[DIV_DW-1:0];
        end
      end
      r_d[g] = r;
      q_d[g] = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[g] <= n_in[g];
        d_q[g] <= d_in[g];
        r_q[g] <= r_d[g];
        q_q[g] <= q_d[g];
      end
    end
  end

  assign q_o = q_q[DIV_STG-1];

endmodule

`default_nettype wire
